// ===== rtl/core/fthd_pkg.sv =====
package fthd_pkg;

	// Status codes shown on the result channel
	localparam logic [2:0] STAT_PENDING  = 3'd0;
	localparam logic [2:0] STAT_OK       = 3'd1;
	localparam logic [2:0] STAT_SHORT    = 3'd2;
	localparam logic [2:0] STAT_BAD_HIST = 3'd3;
	localparam logic [2:0] STAT_OVERRUN  = 3'd4;
	localparam logic [2:0] STAT_TOO_LONG = 3'd5;
	localparam logic [2:0] STAT_SUM_OVF  = 3'd6;
	localparam logic [2:0] STAT_INTERVAL = 3'd7;

	localparam int RANGE_BITS = 14;

	// Request to the shared multiply/divide unit
	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} alu_rsp_t;

endpackage

// ===== rtl/core/frequency_table_header_decoder.sv =====
// Frequency-table header decoder.
// Input channel (in_valid/in_stall) carries one transaction per command:
//   push a header octet, mark end of stream, read a table entry, or restart.
// Every input transaction yields exactly one result transaction on the
// output channel (out_valid/out_stall) with status, done flag, consumed
// length and, for reads after a successful decode, the symbol's range.
// One transaction at a time: in_stall is high while a command is worked
// on and while a result waits to be taken.
// A read or restart goes straight to the result; a push or end of
// stream runs the decoder until it needs another octet or finishes.
// Each symbol step runs on one shared multiply/divide unit: a coarse
// step runs the bucket-search multiplies plus two divides, a fine step
// two multiplies and three divides; octet loads and the tail scan do
// not use the unit.
// Reset (arst_n low) or a restart command clears the decode state; the
// range memory is not swept, since entries are only readable after a
// successful decode has written every entry up to the symbol count.
// When the receiver stalls, the result is held unchanged and no new
// command is taken until it is accepted.
module frequency_table_header_decoder #(
	parameter int SYMBOLS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  stream_byte,
	input  logic [7:0]  symbol_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] range_value,
	output logic [2:0]  status,
	output logic        done_res,
	output logic [15:0] consumed_octets,
	output logic [18:0] consumed_bits
);

	localparam int AW = $clog2(SYMBOLS);
	localparam logic [14:0] VAL_RANGE = 15'(1 << fthd_pkg::RANGE_BITS);

	// commands
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_END     = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	// decode stages
	localparam logic [2:0] ST_COUNT  = 3'd0;
	localparam logic [2:0] ST_HIST   = 3'd1;
	localparam logic [2:0] ST_FILL   = 3'd2;
	localparam logic [2:0] ST_SYM    = 3'd3;
	localparam logic [2:0] ST_RENORM = 3'd4;
	localparam logic [2:0] ST_TAIL   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	// sequencer states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RUN   = 5'd1;
	localparam logic [4:0] S_CHK   = 5'd2;
	localparam logic [4:0] S_OUT   = 5'd3;
	localparam logic [4:0] S_TLOOP = 5'd4;
	localparam logic [4:0] S_CP    = 5'd5;
	localparam logic [4:0] S_CQ    = 5'd6;
	localparam logic [4:0] S_CQW   = 5'd7;
	localparam logic [4:0] S_CSEL  = 5'd8;
	localparam logic [4:0] S_CLOM  = 5'd9;
	localparam logic [4:0] S_CLOD  = 5'd10;
	localparam logic [4:0] S_CWM   = 5'd11;
	localparam logic [4:0] S_CWD   = 5'd12;
	localparam logic [4:0] S_DIFF  = 5'd13;
	localparam logic [4:0] S_FM    = 5'd14;
	localparam logic [4:0] S_FVN   = 5'd15;
	localparam logic [4:0] S_FLOM  = 5'd16;
	localparam logic [4:0] S_FLOD  = 5'd17;
	localparam logic [4:0] S_FWD   = 5'd18;

	// architectural decode state, cleared by reset and restart
	typedef struct packed {
		logic [7:0][7:0]    bc;      // bucket counts
		logic [63:0]        low;     // interval low (carry headroom)
		logic [63:0]        width;
		logic [63:0]        code;
		logic [63:0]        diff;    // renorm difference bits
		logic [7:0]         total;
		logic [8:0]         cursor;
		logic [2:0]         choice;
		logic               coarse;
		logic [24:0]        rsum;
		logic [31:0]        oread;
		logic [31:0]        pushed;
		logic [2:0]         dstage;
		logic signed [11:0] hrem;
		logic [2:0]         sub;
		logic               ended;
		logic               br;      // pushed octet not yet consumed
		logic [7:0]         bval;
		logic [2:0]         stat;
	} arch_t;

	localparam arch_t ArchReset = '{
		width: 64'h0000_FFFF_FFFF_FFFF,
		coarse: 1'b1,
		default: '0
	};

	arch_t st_q;
	logic [4:0] seq_q;

	// step temporaries
	logic [63:0] span_q;
	logic [63:0] dv_q;
	logic [63:0] p_q;
	logic [7:0]  den_q;
	logic [3:0]  ix_q;
	logic [11:0] cnt_q;
	logic [7:0]  r_q;
	logic [15:0] vd_q;
	logic [15:0] vn_q;
	logic [14:0] base_q;
	logic [24:0] last_q;
	logic [3:0]  k_q;
	logic        ovr_q;
	logic [1:0]  cmd_q;
	logic [7:0]  idx_q;

	fthd_pkg::alu_req_t alu_req_q;
	fthd_pkg::alu_rsp_t alu_rsp;

	logic          ram_we_q;
	logic [AW-1:0] ram_waddr_q;
	logic [14:0]   ram_wdata_q;
	logic [14:0]   ram_rdata;

	logic          out_valid_q;
	logic [14:0]   range_q;
	logic [2:0]    status_q;
	logic          done_q;
	logic [15:0]   octets_q;
	logic [18:0]   bits_q;

	logic        in_acc;
	logic        fetch_ok;
	logic [7:0]  fetch_b;
	logic [63:0] hi_w;
	logic        in_int;
	logic [7:0]  den_w;
	logic [3:0]  sh_w;
	logic [15:0] vd_w;
	logic [2:0]  ch_m1;
	logic        ok_w;
	logic [16:0] fine_val;
	logic        cur_in;
	logic        tot_in;
	logic [7:0]  bc_ix;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (seq_q != S_IDLE) || out_valid_q;

	// octet source: pending push, else zero padding after end of stream
	assign fetch_ok = st_q.br || st_q.ended;
	assign fetch_b  = st_q.br ? st_q.bval : 8'd0;

	assign hi_w   = st_q.low + st_q.width;
	assign in_int = (st_q.code >= st_q.low) && (st_q.code <= hi_w);
	assign den_w  = st_q.total - st_q.cursor[7:0];
	assign ch_m1  = st_q.choice - 3'd1;
	assign sh_w   = {ch_m1, 1'b0};
	assign vd_w   = 16'd3 << sh_w;
	assign ok_w   = (st_q.dstage == ST_DONE) && (st_q.stat == fthd_pkg::STAT_OK);
	assign fine_val = 17'(base_q) + 17'(vn_q);
	assign cur_in = st_q.cursor < 9'(SYMBOLS);
	assign tot_in = {1'b0, st_q.total} < 9'(SYMBOLS);
	assign bc_ix  = st_q.bc[ix_q[2:0]];

	fthd_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req_q),
		.rsp    (alu_rsp)
	);

	fthd_ram #(
		.WIDTH (15),
		.DEPTH (SYMBOLS)
	) u_ranges (
		.clk     (clk),
		.wr_en   (ram_we_q),
		.wr_addr (ram_waddr_q),
		.wr_data (ram_wdata_q),
		.rd_en   (in_acc && (command == CMD_READ)),
		.rd_addr (symbol_index[AW-1:0]),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ArchReset;
			seq_q       <= S_IDLE;
			span_q      <= '0;
			dv_q        <= '0;
			p_q         <= '0;
			den_q       <= '0;
			ix_q        <= '0;
			cnt_q       <= '0;
			r_q         <= '0;
			vd_q        <= '0;
			vn_q        <= '0;
			base_q      <= '0;
			last_q      <= '0;
			k_q         <= '0;
			ovr_q       <= 1'b0;
			cmd_q       <= CMD_PUSH;
			idx_q       <= '0;
			alu_req_q   <= '0;
			ram_we_q    <= 1'b0;
			ram_waddr_q <= '0;
			ram_wdata_q <= '0;
			out_valid_q <= 1'b0;
			range_q     <= '0;
			status_q    <= '0;
			done_q      <= 1'b0;
			octets_q    <= '0;
			bits_q      <= '0;
		end else begin
			alu_req_q.start <= 1'b0;
			ram_we_q        <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (seq_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= command;
						idx_q <= symbol_index;
						unique case (command)
							CMD_PUSH: begin
								if (st_q.dstage != ST_DONE && !st_q.ended) begin
									st_q.br   <= 1'b1;
									st_q.bval <= stream_byte;
									if (st_q.pushed != '1) begin
										st_q.pushed <= st_q.pushed + 32'd1;
									end
									seq_q <= S_RUN;
								end else begin
									seq_q <= S_OUT;
								end
							end
							CMD_END: begin
								if (!st_q.ended) begin
									st_q.ended <= 1'b1;
									seq_q      <= S_RUN;
								end else begin
									seq_q <= S_OUT;
								end
							end
							CMD_READ: seq_q <= S_OUT;
							CMD_RESTART: begin
								st_q  <= ArchReset;
								seq_q <= S_OUT;
							end
						endcase
					end
				end

				S_RUN: begin
					unique case (st_q.dstage)
						ST_COUNT: begin
							if (!st_q.br) begin
								if (st_q.ended) begin
									st_q.dstage <= ST_DONE;
									st_q.stat   <= fthd_pkg::STAT_SHORT;
								end
								seq_q <= S_OUT;
							end else begin
								st_q.br     <= 1'b0;
								st_q.total  <= st_q.bval;
								st_q.hrem   <= 12'(st_q.bval);
								st_q.oread  <= 32'd1;
								st_q.sub    <= '0;
								st_q.dstage <= ST_HIST;
							end
						end
						ST_HIST: begin
							if (st_q.sub < 3'd7 && st_q.hrem > 12'sd0) begin
								if (!st_q.br) begin
									if (st_q.ended) begin
										st_q.dstage <= ST_DONE;
										st_q.stat   <= fthd_pkg::STAT_SHORT;
									end
									seq_q <= S_OUT;
								end else begin
									st_q.br           <= 1'b0;
									st_q.bc[st_q.sub] <= st_q.bval;
									st_q.sub          <= st_q.sub + 3'd1;
									st_q.hrem         <= st_q.hrem - $signed({4'd0, st_q.bval});
									st_q.oread        <= st_q.oread + 32'd1;
								end
							end else if (st_q.hrem < 12'sd0) begin
								st_q.dstage <= ST_DONE;
								st_q.stat   <= fthd_pkg::STAT_BAD_HIST;
								seq_q       <= S_OUT;
							end else begin
								if (st_q.hrem > 12'sd0) begin
									st_q.bc[7] <= st_q.hrem[7:0];
								end
								st_q.sub    <= '0;
								st_q.code   <= '0;
								st_q.dstage <= ST_FILL;
							end
						end
						ST_FILL: begin
							if (st_q.sub < 3'd6) begin
								if (!fetch_ok) begin
									seq_q <= S_OUT;
								end else begin
									st_q.br    <= 1'b0;
									st_q.code  <= {st_q.code[55:0], fetch_b};
									st_q.oread <= st_q.oread + 32'd1;
									st_q.sub   <= st_q.sub + 3'd1;
								end
							end else begin
								st_q.dstage <= ST_SYM;
							end
						end
						ST_SYM: begin
							if (st_q.cursor >= {1'b0, st_q.total}) begin
								// tail: trim the length to the octets the
								// final interval really needs
								st_q.oread <= st_q.oread - 32'd5;
								last_q     <= {1'b0, hi_w[63:40]} - 25'd1;
								k_q        <= '0;
								seq_q      <= S_TLOOP;
							end else if (st_q.width < 64'h1000_0000) begin
								if (!fetch_ok) begin
									seq_q <= S_OUT;
								end else begin
									st_q.br    <= 1'b0;
									st_q.low   <= {16'd0, st_q.low[47:32], 32'd0}
										| {24'd0, st_q.low[31:0], 8'd0};
									st_q.width <= {st_q.width[55:0], 8'hFF};
									st_q.code  <= {16'd0, st_q.code[47:32], 32'd0}
										| {24'd0, st_q.code[31:0], fetch_b};
									st_q.oread <= st_q.oread + 32'd1;
									ovr_q      <= 1'b0;
									seq_q      <= S_CHK;
								end
							end else begin
								span_q <= st_q.width + 64'd1;
								dv_q   <= st_q.code - st_q.low;
								den_q  <= den_w;
								alu_req_q.start  <= 1'b1;
								alu_req_q.is_div <= 1'b0;
								alu_req_q.a      <= st_q.code - st_q.low;
								if (st_q.coarse) begin
									alu_req_q.b <= {56'd0, den_w};
									seq_q       <= S_CP;
								end else begin
									vd_q        <= vd_w;
									base_q      <= 15'd1 << sh_w;
									alu_req_q.b <= {48'd0, vd_w};
									seq_q       <= S_FM;
								end
							end
						end
						ST_RENORM: begin
							if (st_q.diff[63:40] != 24'd0) begin
								st_q.cursor <= st_q.cursor + 9'(st_q.coarse);
								st_q.dstage <= ST_SYM;
							end else if (!fetch_ok) begin
								seq_q <= S_OUT;
							end else begin
								st_q.br    <= 1'b0;
								st_q.low   <= {16'd0, st_q.low[39:0], 8'd0};
								st_q.width <= {st_q.width[55:0], 8'hFF};
								st_q.code  <= {16'd0, st_q.code[39:0], fetch_b};
								st_q.oread <= st_q.oread + 32'd1;
								st_q.diff  <= {st_q.diff[55:0], 8'd0};
								ovr_q <= st_q.ended
									&& ({1'b0, st_q.oread} + 33'd1 > {1'b0, st_q.pushed} + 33'd5);
								seq_q <= S_CHK;
							end
						end
						ST_TAIL: begin
							if (st_q.oread <= st_q.pushed) begin
								st_q.dstage <= ST_DONE;
								if (st_q.rsum >= 25'(VAL_RANGE)) begin
									st_q.stat <= fthd_pkg::STAT_SUM_OVF;
								end else begin
									ram_we_q    <= tot_in;
									ram_waddr_q <= st_q.total[AW-1:0];
									ram_wdata_q <= VAL_RANGE - st_q.rsum[14:0];
									st_q.stat   <= fthd_pkg::STAT_OK;
								end
							end else if (st_q.ended) begin
								st_q.dstage <= ST_DONE;
								st_q.stat   <= fthd_pkg::STAT_TOO_LONG;
							end
							seq_q <= S_OUT;
						end
						default: seq_q <= S_OUT;
					endcase
				end

				S_CHK: begin
					if (ovr_q) begin
						st_q.dstage <= ST_DONE;
						st_q.stat   <= fthd_pkg::STAT_OVERRUN;
						seq_q       <= S_OUT;
					end else if (!in_int) begin
						st_q.dstage <= ST_DONE;
						st_q.stat   <= fthd_pkg::STAT_INTERVAL;
						seq_q       <= S_OUT;
					end else begin
						seq_q <= S_RUN;
					end
				end

				S_TLOOP: begin
					if (!k_q[3] && last_q == {1'b0, st_q.low[63:40]}) begin
						last_q     <= 25'd255;
						st_q.oread <= st_q.oread + 32'd1;
						st_q.low   <= {16'd0, st_q.low[39:0], 8'd0};
						k_q        <= k_q + 4'd1;
					end else begin
						st_q.dstage <= ST_TAIL;
						seq_q       <= S_RUN;
					end
				end

				// coarse step: weighted bucket search
				S_CP: begin
					if (alu_rsp.done) begin
						p_q   <= alu_rsp.result;
						ix_q  <= '0;
						cnt_q <= '0;
						seq_q <= S_CQ;
					end
				end
				S_CQ: begin
					if (ix_q[3]) begin
						seq_q <= S_CSEL;
					end else begin
						alu_req_q <= '{start: 1'b1, is_div: 1'b0, a: span_q,
							b: 64'(cnt_q + 12'(bc_ix))};
						seq_q <= S_CQW;
					end
				end
				S_CQW: begin
					if (alu_rsp.done) begin
						if (p_q >= alu_rsp.result) begin
							cnt_q <= cnt_q + 12'(bc_ix);
							ix_q  <= ix_q + 4'd1;
							seq_q <= S_CQ;
						end else begin
							seq_q <= S_CSEL;
						end
					end
				end
				S_CSEL: begin
					if (ix_q[3] || bc_ix == 8'd0) begin
						st_q.dstage <= ST_DONE;
						st_q.stat   <= fthd_pkg::STAT_INTERVAL;
						seq_q       <= S_OUT;
					end else begin
						r_q                <= bc_ix;
						st_q.bc[ix_q[2:0]] <= bc_ix - 8'd1;
						alu_req_q <= '{start: 1'b1, is_div: 1'b0, a: span_q, b: 64'(cnt_q)};
						seq_q     <= S_CLOM;
					end
				end
				S_CLOM: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, is_div: 1'b1,
							a: alu_rsp.result + 64'(den_q) - 64'd1, b: 64'(den_q)};
						seq_q <= S_CLOD;
					end
				end
				S_CLOD: begin
					if (alu_rsp.done) begin
						st_q.low  <= st_q.low + alu_rsp.result;
						alu_req_q <= '{start: 1'b1, is_div: 1'b0, a: span_q, b: 64'(r_q)};
						seq_q     <= S_CWM;
					end
				end
				S_CWM: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, is_div: 1'b1, a: alu_rsp.result,
							b: 64'(den_q)};
						seq_q <= S_CWD;
					end
				end
				S_CWD: begin
					if (alu_rsp.done) begin
						st_q.width  <= alu_rsp.result - 64'd1;
						ram_we_q    <= cur_in;
						ram_waddr_q <= st_q.cursor[AW-1:0];
						ram_wdata_q <= '0;
						st_q.choice <= ix_q[2:0];
						if (ix_q != 4'd0) begin
							st_q.coarse <= 1'b0;
						end
						seq_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					st_q.diff   <= st_q.low ^ hi_w;
					st_q.dstage <= ST_RENORM;
					seq_q       <= S_RUN;
				end

				// fine step: uniform value inside the chosen bucket
				S_FM: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, is_div: 1'b1, a: alu_rsp.result, b: span_q};
						seq_q     <= S_FVN;
					end
				end
				S_FVN: begin
					if (alu_rsp.done) begin
						if (alu_rsp.result > 64'(vd_q)) begin
							st_q.dstage <= ST_DONE;
							st_q.stat   <= fthd_pkg::STAT_INTERVAL;
							seq_q       <= S_OUT;
						end else begin
							vn_q      <= alu_rsp.result[15:0];
							alu_req_q <= '{start: 1'b1, is_div: 1'b0, a: span_q,
								b: {48'd0, alu_rsp.result[15:0]}};
							seq_q <= S_FLOM;
						end
					end
				end
				S_FLOM: begin
					if (alu_rsp.done) begin
						alu_req_q <= '{start: 1'b1, is_div: 1'b1,
							a: alu_rsp.result + 64'(vd_q) - 64'd1, b: 64'(vd_q)};
						seq_q <= S_FLOD;
					end
				end
				S_FLOD: begin
					if (alu_rsp.done) begin
						st_q.low  <= st_q.low + alu_rsp.result;
						alu_req_q <= '{start: 1'b1, is_div: 1'b1, a: span_q, b: 64'(vd_q)};
						seq_q     <= S_FWD;
					end
				end
				S_FWD: begin
					if (alu_rsp.done) begin
						st_q.width  <= alu_rsp.result - 64'd1;
						st_q.coarse <= 1'b1;
						ram_we_q    <= cur_in;
						ram_waddr_q <= st_q.cursor[AW-1:0];
						ram_wdata_q <= fine_val[14:0];
						st_q.rsum   <= st_q.rsum + 25'(fine_val);
						seq_q       <= S_DIFF;
					end
				end

				S_OUT: begin
					// entries above the symbol count read as cleared
					range_q <= (cmd_q == CMD_READ && ok_w && {1'b0, idx_q} < 9'(SYMBOLS)
						&& idx_q <= st_q.total) ? ram_rdata : 15'd0;
					status_q    <= (st_q.dstage == ST_DONE) ? st_q.stat : fthd_pkg::STAT_PENDING;
					done_q      <= st_q.dstage == ST_DONE;
					octets_q    <= ok_w ? st_q.oread[15:0] : 16'd0;
					bits_q      <= ok_w ? {st_q.oread[15:0], 3'd0} : 19'd0;
					st_q.br     <= 1'b0;
					out_valid_q <= 1'b1;
					seq_q       <= S_IDLE;
				end

				default: seq_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign range_value     = range_q;
	assign status          = status_q;
	assign done_res        = done_q;
	assign consumed_octets = octets_q;
	assign consumed_bits   = bits_q;

endmodule

// ===== rtl/core/fthd_ram.sv =====
module fthd_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/fthd_alu.sv =====
// Shared iterative unit: 64x16 shift-add multiply (mod 2^64), 64/64 restoring divide.
module fthd_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  fthd_pkg::alu_req_t req,
	output fthd_pkg::alu_rsp_t rsp
);

	localparam int MUL_BITS = 16;
	localparam int DIV_BITS = 64;

	logic        busy_q;
	logic        div_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] acc_q;
	logic [64:0] rem_q;

	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q[63:0], x_q[63]};
	assign fits  = trial >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= req.is_div;
				cnt_q  <= req.is_div ? 7'(DIV_BITS) : 7'(MUL_BITS);
				x_q    <= req.a;
				y_q    <= req.b;
				acc_q  <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (div_q) begin
					rem_q <= fits ? (trial - {1'b0, y_q}) : trial;
					x_q   <= {x_q[62:0], fits};
				end else begin
					acc_q <= {acc_q[62:0], 1'b0} + (y_q[MUL_BITS-1] ? x_q : 64'd0);
					y_q   <= {y_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = div_q ? x_q : acc_q;

endmodule

// ===== rtl/core/fthd_checker.sv =====
module fthd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [14:0] range_value,
	input logic [2:0]  status,
	input logic        done_res,
	input logic [15:0] consumed_octets,
	input logic [18:0] consumed_bits
);

	// a held result keeps its status
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	// no new command while a result waits
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_pending_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == fthd_pkg::STAT_PENDING)
		else $error("status set before decode finished");

	a_bits_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> consumed_bits == {consumed_octets, 3'd0})
		else $error("bit count differs from octet count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fthd_pkg::STAT_OK |-> consumed_octets == 16'd0
			&& range_value == 15'd0)
		else $error("length or range shown without success");

endmodule

bind frequency_table_header_decoder fthd_checker u_fthd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.range_value     (range_value),
	.status          (status),
	.done_res        (done_res),
	.consumed_octets (consumed_octets),
	.consumed_bits   (consumed_bits)
);
